// File: design/sm4_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sm4_pkg;

    localparam int ROUNDS    = 32;
    localparam int CNT_W     = $clog2(ROUNDS);
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;

    // System parameter FK
    localparam logic [31:0] FK0 = 32'hA3B1BAC6;
    localparam logic [31:0] FK1 = 32'h56AA3350;
    localparam logic [31:0] FK2 = 32'h677D9197;
    localparam logic [31:0] FK3 = 32'hB27022DC;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
    } sm4_block_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } sm4_cipher_t;

    // Four-word working state; index 0 is the oldest word.
    typedef logic [3:0][31:0] sm4_words_t;

    localparam logic [7:0] SBOX [256] = '{
        8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
        8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
        8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
        8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
        8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
        8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
        8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
        8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
        8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
        8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
        8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
        8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
        8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
        8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
        8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
    };

    // Byte-wise S-box substitution
    function automatic logic [31:0] tau(input logic [31:0] v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    // L: rotations 2, 10, 18, 24
    function automatic logic [31:0] lin_enc(input logic [31:0] b);
        return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                 ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
    endfunction

    // L': rotations 13, 23
    function automatic logic [31:0] lin_key(input logic [31:0] b);
        return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
    endfunction

    // CK byte j of word i is (4*i + j) * 7 mod 256
    function automatic logic [31:0] ck_word(input logic [CNT_W-1:0] i);
        logic [31:0] w;
        logic [7:0]  t;
        w = '0;
        for (int j = 0; j < 4; j++) begin
            t = 8'({i, 2'b00}) + 8'(j);
            w = {w[23:0], 8'(t * 8'd7)};
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// File: design/sm4_round.sv
`timescale 1ns / 1ps
`default_nettype none

// One SM4 round, shared by key expansion and block encryption.
module sm4_round (
    input  wire sm4_pkg::sm4_words_t words,
    input  wire logic [31:0]         rk,
    input  wire logic                key_mode,
    output logic [31:0]              result
);

    logic [31:0] sub;

    always_comb begin
        sub = sm4_pkg::tau(words[1] ^ words[2] ^ words[3] ^ rk);
        if (key_mode) begin
            result = words[0] ^ sm4_pkg::lin_key(sub);
        end else begin
            result = words[0] ^ sm4_pkg::lin_enc(sub);
        end
    end

endmodule

`default_nettype wire

// File: design/sm4_block_encrypt_core.sv
`timescale 1ns / 1ps
`default_nettype none

// SM4 block encryption core, one round per clock while not held on a full output.
//
// Input channel s_*: one 128-bit plaintext block per transaction (valid/ready).
// Output channel m_*: one 128-bit ciphertext block per transaction.
// Config port: cfg_wr_en/cfg_index/cfg_wdata writes key_high (index 0) or
// key_low (index 1); other indexes are ignored.
//
// Each key write, and reset, starts a key expansion that fills the round key
// RAM through the shared round unit; s_ready is low meanwhile. A further key
// write during expansion restarts it with the updated key. After reset, the
// core first raises s_ready once that expansion ends.
//
// A block runs through the round loop (one pass of the round unit per cycle,
// round key read from the RAM into a register the cycle before use). The result
// lands in the output register at the edge that ends the last round, as s_ready
// rises; a new block starts only after the last has left the round loop.
// The output register decouples the sides: the next block is accepted while a
// result waits. If the result register is still full when the next block
// reaches its last round, the core holds there until m_ready drains it.
// Reset is synchronous, active low; it drops m_valid and clears the key.
module sm4_block_encrypt_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire sm4_pkg::sm4_block_t             s_data,

    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output sm4_pkg::sm4_cipher_t                 m_data,

    input  wire logic                            cfg_wr_en,
    input  wire logic [sm4_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [63:0]                     cfg_wdata
);

    localparam logic [1:0] ST_KEXP = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    localparam logic [sm4_pkg::CNT_W-1:0] LAST_CNT = sm4_pkg::CNT_W'(sm4_pkg::ROUNDS - 1);

    logic [1:0]                    state_reg, state_next;
    logic [sm4_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    sm4_pkg::sm4_words_t           x_reg, x_next;
    logic [63:0]                   key_high_reg, key_high_next;
    logic [63:0]                   key_low_reg, key_low_next;
    logic                          m_valid_reg, m_valid_next;
    sm4_pkg::sm4_cipher_t          m_data_reg, m_data_next;

    // Round key RAM
    logic [31:0]                   rk_mem [sm4_pkg::ROUNDS];
    logic [31:0]                   rk_rd_reg;
    logic [sm4_pkg::CNT_W-1:0]     rd_addr;
    logic                          rk_we;

    logic                          cfg_hit;
    logic                          s_accept;
    logic                          out_free;
    logic                          key_mode;
    logic [31:0]                   round_key;
    logic [31:0]                   round_out;

    assign cfg_hit  = cfg_wr_en &&
                      (cfg_index == sm4_pkg::REG_KEY_HIGH || cfg_index == sm4_pkg::REG_KEY_LOW);
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign key_mode = (state_reg == ST_KEXP);
    assign round_key = key_mode ? sm4_pkg::ck_word(cnt_reg) : rk_rd_reg;

    sm4_round u_round (
        .words    (x_reg),
        .rk       (round_key),
        .key_mode (key_mode),
        .result   (round_out)
    );

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        x_next        = x_reg;
        key_high_next = key_high_reg;
        key_low_next  = key_low_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        rd_addr       = '0;
        rk_we         = 1'b0;

        if (cfg_hit) begin
            // New key half; restart expansion from FK-whitened key
            if (cfg_index == sm4_pkg::REG_KEY_HIGH) begin
                key_high_next = cfg_wdata;
            end else begin
                key_low_next = cfg_wdata;
            end
            state_next = ST_KEXP;
            cnt_next   = '0;
            x_next[0]  = key_high_next[63:32] ^ sm4_pkg::FK0;
            x_next[1]  = key_high_next[31:0]  ^ sm4_pkg::FK1;
            x_next[2]  = key_low_next[63:32]  ^ sm4_pkg::FK2;
            x_next[3]  = key_low_next[31:0]   ^ sm4_pkg::FK3;
        end else begin
            unique case (state_reg)
                ST_KEXP: begin
                    rk_we     = 1'b1;
                    x_next    = {round_out, x_reg[3], x_reg[2], x_reg[1]};
                    cnt_next  = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_CNT) begin
                        state_next = ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    // rd_addr = 0 prefetches the first round key
                    if (s_accept) begin
                        x_next[0]  = s_data.block_high[63:32];
                        x_next[1]  = s_data.block_high[31:0];
                        x_next[2]  = s_data.block_low[63:32];
                        x_next[3]  = s_data.block_low[31:0];
                        cnt_next   = '0;
                        state_next = ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (cnt_reg != LAST_CNT) begin
                        rd_addr  = cnt_reg + 1'b1;
                        x_next   = {round_out, x_reg[3], x_reg[2], x_reg[1]};
                        cnt_next = cnt_reg + 1'b1;
                    end else begin
                        // hold on the last round until the output slot frees
                        rd_addr = cnt_reg;
                        if (out_free) begin
                            m_valid_next            = 1'b1;
                            m_data_next.cipher_high = {round_out, x_reg[3]};
                            m_data_next.cipher_low  = {x_reg[2], x_reg[1]};
                            state_next              = ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_KEXP;
            cnt_reg      <= '0;
            key_high_reg <= '0;
            key_low_reg  <= '0;
            m_valid_reg  <= 1'b0;
            x_reg        <= {sm4_pkg::FK3, sm4_pkg::FK2, sm4_pkg::FK1, sm4_pkg::FK0};
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            key_high_reg <= key_high_next;
            key_low_reg  <= key_low_next;
            m_valid_reg  <= m_valid_next;
            x_reg        <= x_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (rk_we) begin
            rk_mem[cnt_reg] <= round_out;
        end
        rk_rd_reg <= rk_mem[rd_addr];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A result only appears out of the last round of a block
    a_valid_from_run: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_RUN && cnt_reg == LAST_CNT))
        else $error("result appeared outside the last round");

    // A key write always blocks input for the following expansion
    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_hit |=> (state_reg == ST_KEXP && cnt_reg == '0 && !s_ready))
        else $error("key write did not restart expansion");

    // A stalled last round keeps its state
    a_last_round_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && cnt_reg == LAST_CNT && !out_free && !cfg_hit)
        |=> (state_reg == ST_RUN && $stable(x_reg) && $stable(m_data_reg)))
        else $error("last round advanced into a full output register");

    // An accepted block starts at round zero
    a_accept_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !cfg_hit) |=> (state_reg == ST_RUN && cnt_reg == '0))
        else $error("accepted block did not start the round loop");

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // ------------------------------------------------------------------
    // Constants
    // ------------------------------------------------------------------
    localparam int NUM_ROUNDS = 32;

    // Settle time before a key write: covers a block still in the round
    // loop and a key expansion started by the previous write.
    localparam int KEY_SETTLE = NUM_ROUNDS + 8;

    // Hard stop for the whole run.
    localparam longint RUN_LIMIT_NS = 64'd15_000_000;

    // Indexes past the two key registers; writes there must be dropped.
    localparam logic [sm4_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [sm4_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // Standard test vector: key and plaintext 0123..3210
    localparam logic [127:0] KAT_KEY    = 128'h0123456789abcdeffedcba9876543210;
    localparam logic [127:0] KAT_CIPHER = 128'h681edf34d206965e86b3e94f536e4246;

    localparam logic [31:0] FK_WORD [4] = '{
        32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
    };

    localparam logic [7:0] S_TABLE [256] = '{
        8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
        8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
        8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
        8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
        8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
        8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
        8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
        8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
        8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
        8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
        8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
        8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
        8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
        8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
        8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
    };

    // Receiver pacing modes
    typedef enum logic [1:0] {
        SINK_OPEN,      // always ready
        SINK_COIN,      // ready half the time
        SINK_SPARSE,    // ready about one cycle in eight
        SINK_PERIODIC   // fixed on/off pattern
    } sink_mode_e;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    logic                              s_valid   = 1'b0;
    logic                              s_ready;
    sm4_pkg::sm4_block_t               s_data    = '0;
    logic                              m_valid;
    logic                              m_ready   = 1'b0;
    sm4_pkg::sm4_cipher_t              m_data;
    logic                              cfg_wr_en = 1'b0;
    logic [sm4_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [63:0]                       cfg_wdata = '0;

    sm4_block_encrypt_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    sm4_pkg::sm4_cipher_t expected_cipher[$];   // one entry per accepted block
    int unsigned          mismatch_count    = 0;
    int unsigned          hold_sink_cycles  = 0; // long receiver hold-off request

    // Key as the core should hold it, and the round keys derived from it
    logic [63:0] key_high_q;
    logic [63:0] key_low_q;
    logic [31:0] round_key [NUM_ROUNDS];

    // ------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------
    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Cipher predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] rotl32(input logic [31:0] w, input int unsigned n);
        return (w << n) | (w >> (32 - n));
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {S_TABLE[w[31:24]], S_TABLE[w[23:16]], S_TABLE[w[15:8]], S_TABLE[w[7:0]]};
    endfunction

    // Diffusion used in the data rounds
    function automatic logic [31:0] mix_data(input logic [31:0] b);
        return b ^ rotl32(b, 2) ^ rotl32(b, 10) ^ rotl32(b, 18) ^ rotl32(b, 24);
    endfunction

    // Lighter diffusion used in the key schedule
    function automatic logic [31:0] mix_key(input logic [31:0] b);
        return b ^ rotl32(b, 13) ^ rotl32(b, 23);
    endfunction

    // Byte j of constant i is (4i + j) * 7 mod 256
    function automatic logic [31:0] key_round_const(input int unsigned i);
        logic [31:0] w;
        w = '0;
        for (int j = 0; j < 4; j++)
            w = {w[23:0], 8'(((4 * i + j) * 7) % 256)};
        return w;
    endfunction

    function automatic void expand_round_keys();
        logic [31:0] k [4];
        logic [31:0] nk;
        k[0] = key_high_q[63:32] ^ FK_WORD[0];
        k[1] = key_high_q[31:0]  ^ FK_WORD[1];
        k[2] = key_low_q[63:32]  ^ FK_WORD[2];
        k[3] = key_low_q[31:0]   ^ FK_WORD[3];
        for (int i = 0; i < NUM_ROUNDS; i++) begin
            nk = k[0] ^ mix_key(sbox_word(k[1] ^ k[2] ^ k[3] ^ key_round_const(i)));
            round_key[i] = nk;
            k[0] = k[1];
            k[1] = k[2];
            k[2] = k[3];
            k[3] = nk;
        end
    endfunction

    function automatic sm4_pkg::sm4_cipher_t encrypt_block(input sm4_pkg::sm4_block_t blk);
        logic [31:0]          x [4];
        logic [31:0]          nx;
        sm4_pkg::sm4_cipher_t c;
        x[0] = blk.block_high[63:32];
        x[1] = blk.block_high[31:0];
        x[2] = blk.block_low[63:32];
        x[3] = blk.block_low[31:0];
        for (int r = 0; r < NUM_ROUNDS; r++) begin
            nx = x[0] ^ mix_data(sbox_word(x[1] ^ x[2] ^ x[3] ^ round_key[r]));
            x[0] = x[1];
            x[1] = x[2];
            x[2] = x[3];
            x[3] = nx;
        end
        // Output is the last four words in reversed order
        c.cipher_high = {x[3], x[2]};
        c.cipher_low  = {x[1], x[0]};
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [63:0] random_word64();
        logic [63:0] one_hot;
        one_hot = 64'd1 << $urandom_range(0, 63);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return one_hot;
            3:       return ~one_hot;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic sm4_pkg::sm4_block_t random_block();
        sm4_pkg::sm4_block_t b;
        b.block_high = random_word64();
        b.block_low  = random_word64();
        return b;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Offer one block and hold it until accepted. Valid is left high so a
    // following call continues the burst without a bubble.
    task automatic send_block(input sm4_pkg::sm4_block_t blk);
        s_valid <= 1'b1;
        s_data  <= blk;
        do @(posedge aclk); while (s_ready !== 1'b1);
        expected_cipher.push_back(encrypt_block(blk));
    endtask

    task automatic idle_sender(input int unsigned cycles);
        if (cycles != 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every pending ciphertext has come back.
    // Always waits for a clock edge first, so back-to-back calls drive s_valid
    // at different edges.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_cipher.size() != 0) @(posedge aclk);
    endtask

    // Key register write. Only done with the core drained and settled.
    task automatic write_key_reg(input logic [sm4_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [63:0] value);
        wait_for_results();
        repeat (KEY_SETTLE) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == sm4_pkg::REG_KEY_HIGH) begin
            key_high_q = value;
            expand_round_keys();
        end else if (idx == sm4_pkg::REG_KEY_LOW) begin
            key_low_q = value;
            expand_round_keys();
        end
        // any other index leaves the key untouched
    endtask

    task automatic load_key(input logic [127:0] key);
        write_key_reg(sm4_pkg::REG_KEY_HIGH, key[127:64]);
        write_key_reg(sm4_pkg::REG_KEY_LOW, key[63:0]);
    endtask

    // Random traffic: bursts of random length, random gaps, occasional
    // full drains so the sender also pauses on an empty pipeline.
    task automatic run_random_items(input int unsigned count);
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < count; i++) begin
                send_block(random_block());
                sent++;
            end
            case ($urandom_range(0, 7))
                0, 1:    ;                               // no gap
                2:       wait_for_results();
                default: idle_sender($urandom_range(1, 45));
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Core comes out of reset with the all-zero key expanded
    task automatic test_reset_key();
        send_block('0);
        send_block('1);
    endtask

    // Published vector; also guards the predictor itself
    task automatic test_known_answer();
        sm4_pkg::sm4_cipher_t kat;
        load_key(KAT_KEY);
        kat = encrypt_block(KAT_KEY);
        if (kat !== KAT_CIPHER)
            flag_mismatch($sformatf("predictor KAT got %h", kat));
        send_block(KAT_KEY);
    endtask

    // Extreme plaintext patterns under the all-ones key
    task automatic test_field_extremes();
        load_key('1);
        send_block('0);
        send_block('1);
        send_block({2{64'h5555_5555_5555_5555}});
        send_block({64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_0000_0000_0001});
        send_block({64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFE});
    endtask

    // Rewriting one half must keep the other half as it was
    task automatic test_partial_key();
        write_key_reg(sm4_pkg::REG_KEY_HIGH, 64'hFEDC_BA98_7654_3210);
        send_block({64'h0123_4567_89AB_CDEF, 64'h0});
        write_key_reg(sm4_pkg::REG_KEY_LOW, 64'h0);
        send_block({64'h0, 64'h0123_4567_89AB_CDEF});
    endtask

    // Writes to unused indexes are dropped; round keys unchanged
    task automatic test_spare_index();
        write_key_reg(REG_SPARE_2, 64'hDEAD_BEEF_CAFE_F00D);
        send_block(KAT_KEY);
        write_key_reg(REG_SPARE_3, '1);
        send_block('0);
    endtask

    // Same block before and after a key change
    task automatic test_key_change();
        sm4_pkg::sm4_block_t blk;
        blk = random_block();
        send_block(blk);
        load_key({$urandom, $urandom, $urandom, $urandom});
        send_block(blk);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering;
    // the core fills, drops s_ready, and drains once the hold ends.
    task automatic test_output_backpressure();
        wait_for_results();
        hold_sink_cycles = 400;
        for (int i = 0; i < 8; i++)
            send_block(random_block());
        wait_for_results();
    endtask

    // Several key settings, extremes first, each followed by random traffic
    task automatic test_random_traffic();
        for (int phase = 0; phase < 15; phase++) begin
            case (phase)
                0:       load_key('0);
                1:       load_key('1);
                default: begin
                    case ($urandom_range(0, 3))
                        0: load_key({$urandom, $urandom, $urandom, $urandom});
                        1: write_key_reg(sm4_pkg::REG_KEY_HIGH, random_word64());
                        2: write_key_reg(sm4_pkg::REG_KEY_LOW, random_word64());
                        3: begin
                            write_key_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                                          {$urandom, $urandom});
                            write_key_reg(sm4_pkg::REG_KEY_HIGH, random_word64());
                        end
                    endcase
                end
            endcase
            run_random_items(100);
            if (phase == 7)
                test_output_backpressure();
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver pacing: its own pattern, plus the long hold-off on request
    // ------------------------------------------------------------------
    initial begin : sink_pacing
        sink_mode_e  mode;
        int unsigned left;
        int unsigned tick;
        int unsigned period;
        int unsigned duty;
        mode   = SINK_OPEN;
        left   = 0;
        tick   = 0;
        period = 2;
        duty   = 1;
        forever begin
            @(posedge aclk);
            tick++;
            if (left == 0) begin
                mode   = sink_mode_e'($urandom_range(0, 3));
                left   = $urandom_range(50, 400);
                period = $urandom_range(2, 40);
                duty   = $urandom_range(1, period - 1);
            end
            left--;
            if (hold_sink_cycles != 0) begin
                hold_sink_cycles--;
                m_ready <= 1'b0;
            end else if (mode == SINK_OPEN)
                m_ready <= 1'b1;
            else if (mode == SINK_COIN)
                m_ready <= 1'($urandom_range(0, 1));
            else if (mode == SINK_SPARSE)
                m_ready <= ($urandom_range(0, 7) == 0);
            else
                m_ready <= ((tick % period) < duty);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every output transaction against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        sm4_pkg::sm4_cipher_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (expected_cipher.size() == 0) begin
                flag_mismatch($sformatf("unexpected result %h", m_data));
            end else begin
                want = expected_cipher.pop_front();
                if (m_data.cipher_high !== want.cipher_high)
                    flag_mismatch($sformatf("cipher_high got %h want %h",
                                            m_data.cipher_high, want.cipher_high));
                if (m_data.cipher_low !== want.cipher_low)
                    flag_mismatch($sformatf("cipher_low got %h want %h",
                                            m_data.cipher_low, want.cipher_low));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_sequence
        key_high_q = '0;
        key_low_q  = '0;
        expand_round_keys();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_key();
        test_known_answer();
        test_field_extremes();
        test_partial_key();
        test_spare_index();
        test_key_change();
        test_random_traffic();

        // drain, then leave room for any stray output transaction
        wait_for_results();
        repeat (NUM_ROUNDS + 8) @(posedge aclk);
        if (mismatch_count == 0 && expected_cipher.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
